// ----- rtl/xsp_pkg.sv -----
// ----------------------------------------------------------------------------
// xsp_pkg: shared types and constants of the scalar text parser
// target mode codes, status codes, character codes and the string summary
// ----------------------------------------------------------------------------
`default_nettype none

package xsp_pkg;

   localparam logic [3:0] MODE_BOOL = 4'd0;
   localparam logic [3:0] MODE_S8   = 4'd1;
   localparam logic [3:0] MODE_U8   = 4'd2;
   localparam logic [3:0] MODE_S16  = 4'd3;
   localparam logic [3:0] MODE_U16  = 4'd4;
   localparam logic [3:0] MODE_S32  = 4'd5;
   localparam logic [3:0] MODE_U32  = 4'd6;
   localparam logic [3:0] MODE_S64  = 4'd7;
   localparam logic [3:0] MODE_U64  = 4'd8;
   localparam logic [3:0] MODE_CHAR = 4'd9;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FORMAT   = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // literal bits in order true, false, 1, 0
   localparam int LIT_TRUE  = 0;
   localparam int LIT_FALSE = 1;
   localparam int LIT_ONE   = 2;
   localparam int LIT_NULL  = 3;

   typedef struct packed {
      logic        too_long;
      logic        body_zero;
      logic        body_one;
      logic        body_four;
      logic        body_five;
      logic        negative;
      logic        digit_seen;
      logic        digits_ovf;
      logic        format_bad;
      logic [7:0]  first_byte;
      logic [3:0]  word_match;
      logic [63:0] magnitude;
   } summary_type;

   function automatic logic is_trim(input logic [7:0] b);
      return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
   endfunction

   // mask of literals whose character at pos equals b
   function automatic logic [3:0] lit_hit(input logic [2:0] pos, input logic in_range,
                                          input logic [7:0] b);
      logic [3:0] hit;
      hit = 4'b0000;
      if (in_range) begin
         case (pos)
            3'd0: begin
               hit[LIT_TRUE]  = (b == "t");
               hit[LIT_FALSE] = (b == "f");
               hit[LIT_ONE]   = (b == "1");
               hit[LIT_NULL]  = (b == "0");
            end
            3'd1: begin
               hit[LIT_TRUE]  = (b == "r");
               hit[LIT_FALSE] = (b == "a");
            end
            3'd2: begin
               hit[LIT_TRUE]  = (b == "u");
               hit[LIT_FALSE] = (b == "l");
            end
            3'd3: begin
               hit[LIT_TRUE]  = (b == "e");
               hit[LIT_FALSE] = (b == "s");
            end
            3'd4: begin
               hit[LIT_FALSE] = (b == "e");
            end
            default: begin
               hit = 4'b0000;
            end
         endcase
      end
      return hit;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/xsp_req_if.sv -----
// ----------------------------------------------------------------------------
// xsp_req_if: input channel of the scalar text parser
// one string byte per word with target mode and end markers
// ----------------------------------------------------------------------------
`default_nettype none

interface xsp_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] mode;
   logic [7:0] char_byte;
   logic       no_byte;
   logic       last;

   modport source (output valid, output mode, output char_byte, output no_byte,
                   output last, input ready);
   modport sink (input valid, input mode, input char_byte, input no_byte,
                 input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/xsp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// xsp_rsp_if: result channel of the scalar text parser
// one decoded value and status per word
// ----------------------------------------------------------------------------
`default_nettype none

interface xsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [1:0]  status;

   modport source (output valid, output value, output status, input ready);
   modport sink (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/xsp_accum.sv -----
// ----------------------------------------------------------------------------
// xsp_accum: per-string scan state
// trims whitespace, tracks literal matches, sign and decimal magnitude
// ----------------------------------------------------------------------------
`default_nettype none

module xsp_accum
   import xsp_pkg::*;
#(
   parameter int BUFFER_BYTES = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic [7:0]  char_byte,
   input  wire logic        no_byte,
   input  wire logic        last,
   output summary_type      summary
);

   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam logic [CW-1:0] CNT_MAX = CW'(BUFFER_BYTES);

   localparam logic [1:0] PH_LEAD  = 2'd0;
   localparam logic [1:0] PH_BODY  = 2'd1;
   localparam logic [1:0] PH_TRAIL = 2'd2;

   logic [1:0]    phase_ff, phase_in;
   logic [CW-1:0] raw_cnt_ff, raw_cnt_in;
   logic [CW-1:0] body_cnt_ff, body_cnt_in;
   logic          neg_ff, neg_in;
   logic          digit_ff, digit_in;
   logic [63:0]   mag_ff, mag_in;
   logic          ovf_ff, ovf_in;
   logic          bad_ff, bad_in;
   logic [7:0]    first_ff, first_in;
   logic [3:0]    wm_ff, wm_in;

   logic [CW-1:0] pos;
   logic [31:0]   pos_wide;
   logic [67:0]   mag_wide;
   logic [67:0]   prod;
   logic [3:0]    digit;
   logic          ends;

   assign ends     = no_byte || last;
   assign digit    = 4'(char_byte - CH_ZERO);
   assign mag_wide = {4'b0000, mag_ff};
   assign prod     = (mag_wide << 3) + (mag_wide << 1) + {64'd0, digit};

   always_comb begin
      phase_in    = phase_ff;
      raw_cnt_in  = raw_cnt_ff;
      body_cnt_in = body_cnt_ff;
      neg_in      = neg_ff;
      digit_in    = digit_ff;
      mag_in      = mag_ff;
      ovf_in      = ovf_ff;
      bad_in      = bad_ff;
      first_in    = first_ff;
      wm_in       = wm_ff;
      pos         = body_cnt_ff;
      pos_wide    = 32'(pos);
      if (!no_byte) begin
         if (raw_cnt_ff < CNT_MAX) begin
            raw_cnt_in = raw_cnt_ff + 1'b1;
         end
         if (is_trim(char_byte)) begin
            if (phase_ff == PH_BODY) begin
               phase_in = PH_TRAIL;
            end
         end else begin
            // inner whitespace spoils the body
            if (phase_ff == PH_TRAIL) begin
               wm_in  = 4'b0000;
               bad_in = 1'b1;
               if (body_cnt_in < CNT_MAX) begin
                  body_cnt_in = body_cnt_in + 1'b1;
               end
            end
            phase_in = PH_BODY;
            pos      = body_cnt_in;
            pos_wide = 32'(pos);
            if (pos == '0) begin
               first_in = char_byte;
            end
            wm_in = wm_in & lit_hit(3'(pos_wide), pos_wide < 32'd5, char_byte);
            if (!bad_in) begin
               if (((char_byte == CH_PLUS) || (char_byte == CH_MINUS)) && (pos == '0)) begin
                  neg_in = (char_byte == CH_MINUS);
               end else if ((char_byte >= CH_ZERO) && (char_byte <= CH_NINE)) begin
                  digit_in = 1'b1;
                  if (!ovf_ff) begin
                     if (prod[67:64] != 4'b0000) begin
                        ovf_in = 1'b1;
                     end else begin
                        mag_in = prod[63:0];
                     end
                  end
               end else begin
                  bad_in = 1'b1;
               end
            end
            if (body_cnt_in < CNT_MAX) begin
               body_cnt_in = body_cnt_in + 1'b1;
            end
         end
      end
   end

   always_comb begin
      summary.too_long   = (raw_cnt_in >= CNT_MAX);
      summary.body_zero  = (body_cnt_in == '0);
      summary.body_one   = (32'(body_cnt_in) == 32'd1);
      summary.body_four  = (32'(body_cnt_in) == 32'd4);
      summary.body_five  = (32'(body_cnt_in) == 32'd5);
      summary.negative   = neg_in;
      summary.digit_seen = digit_in;
      summary.digits_ovf = ovf_in;
      summary.format_bad = bad_in;
      summary.first_byte = first_in;
      summary.word_match = wm_in;
      summary.magnitude  = mag_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && ends)) begin
         phase_ff    <= PH_LEAD;
         raw_cnt_ff  <= '0;
         body_cnt_ff <= '0;
         neg_ff      <= 1'b0;
         digit_ff    <= 1'b0;
         mag_ff      <= 64'd0;
         ovf_ff      <= 1'b0;
         bad_ff      <= 1'b0;
         first_ff    <= 8'd0;
         wm_ff       <= 4'b1111;
      end else if (step) begin
         phase_ff    <= phase_in;
         raw_cnt_ff  <= raw_cnt_in;
         body_cnt_ff <= body_cnt_in;
         neg_ff      <= neg_in;
         digit_ff    <= digit_in;
         mag_ff      <= mag_in;
         ovf_ff      <= ovf_in;
         bad_ff      <= bad_in;
         first_ff    <= first_in;
         wm_ff       <= wm_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/xsp_finish.sv -----
// ----------------------------------------------------------------------------
// xsp_finish: result formation for one completed string
// picks bool, char or integer result and checks range and format
// ----------------------------------------------------------------------------
`default_nettype none

module xsp_finish
   import xsp_pkg::*;
(
   input  wire logic [3:0]  mode,
   input  summary_type      summary,
   output logic [63:0]      value,
   output logic [1:0]       status
);

   logic        is_signed;
   logic        range64;
   logic        target_ovf;
   logic [63:0] max_pos;
   logic [63:0] mag;
   logic [63:0] mag_neg;

   assign mag       = summary.magnitude;
   assign mag_neg   = ~mag + 64'd1;
   assign is_signed = mode[0];

   always_comb begin
      unique case (mode)
         MODE_S8:  max_pos = 64'h0000_0000_0000_007F;
         MODE_U8:  max_pos = 64'h0000_0000_0000_00FF;
         MODE_S16: max_pos = 64'h0000_0000_0000_7FFF;
         MODE_U16: max_pos = 64'h0000_0000_0000_FFFF;
         MODE_S32: max_pos = 64'h0000_0000_7FFF_FFFF;
         MODE_U32: max_pos = 64'h0000_0000_FFFF_FFFF;
         MODE_S64: max_pos = 64'h7FFF_FFFF_FFFF_FFFF;
         default:  max_pos = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
   end

   always_comb begin
      if (is_signed) begin
         range64 = summary.digits_ovf ||
                   (summary.negative ? (mag > 64'h8000_0000_0000_0000)
                                     : (mag > 64'h7FFF_FFFF_FFFF_FFFF));
         // negative limit is one past the positive one
         target_ovf = summary.negative ? ((mag != 64'd0) && ((mag - 64'd1) > max_pos))
                                       : (mag > max_pos);
      end else begin
         range64    = summary.digits_ovf;
         target_ovf = (mag > max_pos);
      end
   end

   always_comb begin
      value  = 64'd0;
      status = ST_FORMAT;
      if (!summary.too_long && (mode <= MODE_CHAR)) begin
         case (mode)
            MODE_BOOL: begin
               if ((summary.word_match[LIT_TRUE] && summary.body_four) ||
                   (summary.word_match[LIT_ONE] && summary.body_one)) begin
                  value  = 64'd1;
                  status = ST_OK;
               end else if ((summary.word_match[LIT_FALSE] && summary.body_five) ||
                            (summary.word_match[LIT_NULL] && summary.body_one)) begin
                  status = ST_OK;
               end
            end
            MODE_CHAR: begin
               if (summary.body_one) begin
                  value  = {56'd0, summary.first_byte};
                  status = ST_OK;
               end
            end
            default: begin
               if (summary.body_zero) begin
                  status = ST_FORMAT;
               end else if (!is_signed && (summary.first_byte == CH_MINUS)) begin
                  status = ST_FORMAT;
               end else if (range64) begin
                  status = ST_OVERFLOW;
               end else if (summary.format_bad || !summary.digit_seen) begin
                  status = ST_FORMAT;
               end else if (target_ovf) begin
                  status = ST_OVERFLOW;
               end else begin
                  value  = (is_signed && summary.negative) ? mag_neg : mag;
                  status = ST_OK;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/xsd_scalar_text_parser_unit.sv -----
// ----------------------------------------------------------------------------
// xsd_scalar_text_parser_unit: decimal / boolean / char text decoder
// decodes one trimmed short string, fed a byte per word, into a 64-bit result
// ----------------------------------------------------------------------------
//   channel | dir | handshake     | payload
//   req_bus | in  | valid / ready | mode, char_byte, no_byte, last
//   rsp_bus | out | valid / ready | value, status
//
//   one byte word per cycle sustained unless an ending word waits on the
//   summary stage; a result passes the summary, then the result stage
//   the scan loop is one multiply-by-ten add per byte on the magnitude register
//   reset clears all scan state and empties every stage
//   a stalled result holds the summary stage, then an ending input word, then ready
// ----------------------------------------------------------------------------
`default_nettype none

module xsd_scalar_text_parser_unit
   import xsp_pkg::*;
#(
   parameter int BUFFER_BYTES = 128
) (
   input wire logic  clock,
   input wire logic  reset,
   xsp_req_if.sink   req_bus,
   xsp_rsp_if.source rsp_bus
);

   logic        in_valid_ff;
   logic [3:0]  in_mode_ff;
   logic [7:0]  in_byte_ff;
   logic        in_no_byte_ff;
   logic        in_last_ff;

   logic        sum_valid_ff;
   logic [3:0]  sum_mode_ff;
   summary_type sum_ff;

   logic        rsp_valid_ff;
   logic [63:0] rsp_value_ff;
   logic [1:0]  rsp_status_ff;

   summary_type summary;
   logic [63:0] res_value;
   logic [1:0]  res_status;
   logic        in_ends;
   logic        in_go;
   logic        sum_go;
   logic        sum_free;
   logic        rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign sum_go   = sum_valid_ff && rsp_free;
   assign sum_free = !sum_valid_ff || sum_go;
   assign in_ends  = in_no_byte_ff || in_last_ff;
   assign in_go    = in_valid_ff && (!in_ends || sum_free);

   assign req_bus.ready  = !in_valid_ff || in_go;
   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.value  = rsp_value_ff;
   assign rsp_bus.status = rsp_status_ff;

   xsp_accum #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .step      (in_go),
      .char_byte (in_byte_ff),
      .no_byte   (in_no_byte_ff),
      .last      (in_last_ff),
      .summary   (summary)
   );

   xsp_finish u_finish (
      .mode    (sum_mode_ff),
      .summary (sum_ff),
      .value   (res_value),
      .status  (res_status)
   );

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.valid && req_bus.ready) begin
         in_valid_ff <= 1'b1;
      end else if (in_go) begin
         in_valid_ff <= 1'b0;
      end
      if (req_bus.valid && req_bus.ready) begin
         in_mode_ff    <= req_bus.mode;
         in_byte_ff    <= req_bus.char_byte;
         in_no_byte_ff <= req_bus.no_byte;
         in_last_ff    <= req_bus.last;
      end
   end

   // summary stage
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else if (in_go && in_ends) begin
         sum_valid_ff <= 1'b1;
      end else if (sum_go) begin
         sum_valid_ff <= 1'b0;
      end
      if (in_go && in_ends) begin
         sum_mode_ff <= in_mode_ff;
         sum_ff      <= summary;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (sum_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (sum_go) begin
         rsp_value_ff  <= res_value;
         rsp_status_ff <= res_status;
      end
   end

`ifndef NO_ASSERTIONS
   a_ready_low_busy: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> in_valid_ff)
      else $error("ready low with empty input stage");

   a_end_reaches_summary: assert property (@(posedge clock) disable iff (reset)
      in_go && in_ends |=> sum_valid_ff)
      else $error("ending word did not reach summary stage");

   a_summary_holds: assert property (@(posedge clock) disable iff (reset)
      sum_valid_ff && !rsp_free |=> sum_valid_ff && $stable(sum_ff))
      else $error("summary dropped during stall");

   a_error_zero_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != ST_OK) |-> rsp_value_ff == 64'd0)
      else $error("nonzero value on error result");
`endif

endmodule

`default_nettype wire
